### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL. Synthesis builds define SYNTH so that
// the macros expand to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication on the rising edge of clk_i, off during reset.
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication on the rising edge of clk_i, off during reset.
`define ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMP(lbl, ante, cons)
`define ASSERT_NXT(lbl, ante, cons)

`endif

`endif

### hw/rtl/srsw_pkg.sv
package srsw_pkg;

  localparam int unsigned DEF_WINDOW_SLOTS = 16;
  localparam int unsigned SEND_CAP         = 16;

  localparam logic [4:0]  RST_WINDOW_SIZE   = 5'd16;
  localparam logic [31:0] RST_TOTAL_PACKETS = 32'd0;
  localparam logic [7:0]  RST_MAX_RETRY     = 8'd5;

  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_ACK     = 2'd1,
    OP_TIMEOUT = 2'd2,
    OP_DONE    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_RUNNING   = 2'd0,
    ST_COMPLETED = 2'd1,
    ST_EXHAUSTED = 2'd2,
    ST_IGNORED   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CFG_WINDOW_SIZE   = 2'd0,
    CFG_TOTAL_PACKETS = 2'd1,
    CFG_MAX_RETRY     = 2'd2,
    CFG_UNUSED        = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] ack_seq;
  } in_item_t;

  typedef struct packed {
    logic        is_send;
    logic        is_resend;
    logic [3:0]  slot;
    logic [31:0] send_seq;
    logic [1:0]  status;
    logic        last;
  } out_item_t;

  // Decoded request as it travels from the front end to the engine.
  typedef struct packed {
    op_e         op;
    logic [31:0] ack_seq;
  } cmd_t;

endpackage

### hw/rtl/srsw_front.sv
module srsw_front
  import srsw_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_i,
  output logic     q_valid_o,
  input  logic     q_pop_i,
  output cmd_t     q_cmd_o
);

  // Two-entry queue of decoded requests.
  cmd_t       mem_q [2];
  logic       wr_q;
  logic       rd_q;
  logic [1:0] cnt_q;
  logic       push;
  logic       pop;
  cmd_t       cmd_in;

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_cmd_o    = mem_q[rd_q];

  always_comb begin
    cmd_in.ack_seq = in_i.ack_seq;
    unique case (in_i.op)
      2'd0:    cmd_in.op = OP_START;
      2'd1:    cmd_in.op = OP_ACK;
      2'd2:    cmd_in.op = OP_TIMEOUT;
      default: cmd_in.op = OP_DONE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wr_q <= !wr_q;
      end
      if (pop) begin
        rd_q <= !rd_q;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

### hw/rtl/srsw_back.sv
module srsw_back
  import srsw_pkg::*;
#(
  parameter int unsigned WINDOW_SLOTS = DEF_WINDOW_SLOTS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  output logic        q_pop_o,
  input  cmd_t        q_cmd_i,
  input  logic [4:0]  w_eff_i,
  input  logic [31:0] total_i,
  input  logic [7:0]  max_retry_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_o
);

  localparam int unsigned IW = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
  localparam int unsigned CW = $clog2(WINDOW_SLOTS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_MATCH,
    S_BASE,
    S_TX,
    S_FINAL
  } state_e;

  state_e               state_q;
  state_e               ret_q;
  logic [31:0]          seq_q [WINDOW_SLOTS];
  logic [WINDOW_SLOTS-1:0] valid_q;
  logic [WINDOW_SLOTS-1:0] sent_q;
  logic [WINDOW_SLOTS-1:0] acked_q;
  logic [31:0]          base_q;
  logic [31:0]          next_q;
  logic [7:0]           retry_q;
  logic                 sending_q;
  logic [CW-1:0]        cnt_q;
  logic [4:0]           n_q;
  logic                 again_q;
  status_e              status_q;
  logic [31:0]          ack_q;
  logic                 out_valid_q;
  out_item_t            out_q;

  logic [IW-1:0] idx;
  logic          last_w;
  logic          last_all;
  logic          in_win;
  logic          out_free;
  logic          need;
  logic [31:0]   want;
  logic [7:0]    retry_inc;
  logic          has_more;

  assign idx       = cnt_q[IW-1:0];
  assign last_w    = (32'(cnt_q) == 32'(w_eff_i) - 32'd1);
  assign last_all  = (32'(cnt_q) == 32'(WINDOW_SLOTS - 1));
  assign in_win    = (32'(cnt_q) < 32'(w_eff_i));
  assign out_free  = !out_valid_q || !out_stall_i;
  assign need      = valid_q[idx] && (!sent_q[idx] || (again_q && !acked_q[idx]));
  assign want      = base_q + 32'd1;
  assign retry_inc = (retry_q == 8'hFF) ? 8'hFF : retry_q + 8'd1;
  assign has_more  = (next_q < total_i);
  assign q_pop_o   = (state_q == S_IDLE) && q_valid_i;

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_FINAL;
      for (int i = 0; i < int'(WINDOW_SLOTS); i++) begin
        seq_q[i] <= 32'd0;
      end
      valid_q     <= '0;
      sent_q      <= '0;
      acked_q     <= '0;
      base_q      <= '1;
      next_q      <= 32'd0;
      retry_q     <= 8'd0;
      sending_q   <= 1'b0;
      cnt_q       <= '0;
      n_q         <= 5'd0;
      again_q     <= 1'b0;
      status_q    <= ST_RUNNING;
      ack_q       <= 32'd0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            ack_q    <= q_cmd_i.ack_seq;
            n_q      <= 5'd0;
            cnt_q    <= '0;
            status_q <= ST_RUNNING;
            again_q  <= 1'b0;
            ret_q    <= S_FINAL;
            unique case (q_cmd_i.op)
              OP_START: begin
                if (sending_q) begin
                  status_q <= ST_IGNORED;
                  state_q  <= S_FINAL;
                end else begin
                  base_q    <= '1;
                  next_q    <= 32'd0;
                  retry_q   <= 8'd0;
                  sending_q <= 1'b1;
                  state_q   <= S_LOAD;
                end
              end
              OP_ACK: begin
                if (!sending_q) begin
                  status_q <= ST_IGNORED;
                  state_q  <= S_FINAL;
                end else begin
                  state_q <= S_MATCH;
                end
              end
              OP_TIMEOUT: begin
                if (!sending_q) begin
                  status_q <= ST_IGNORED;
                  state_q  <= S_FINAL;
                end else begin
                  retry_q <= retry_inc;
                  if (retry_inc >= max_retry_i) begin
                    sending_q <= 1'b0;
                    status_q  <= ST_EXHAUSTED;
                    state_q   <= S_FINAL;
                  end else begin
                    again_q <= 1'b1;
                    state_q <= S_TX;
                  end
                end
              end
              default: begin
                if (sending_q) begin
                  sending_q <= 1'b0;
                  status_q  <= ST_COMPLETED;
                end else begin
                  status_q <= ST_IGNORED;
                end
                state_q <= S_FINAL;
              end
            endcase
          end
        end

        S_LOAD: begin
          sent_q[idx]  <= 1'b0;
          acked_q[idx] <= 1'b0;
          if (in_win && has_more) begin
            seq_q[idx]   <= next_q;
            valid_q[idx] <= 1'b1;
            next_q       <= next_q + 32'd1;
          end else begin
            valid_q[idx] <= 1'b0;
          end
          if (last_all) begin
            cnt_q   <= '0;
            again_q <= 1'b0;
            ret_q   <= S_FINAL;
            state_q <= S_TX;
          end else begin
            cnt_q <= cnt_q + CW'(1);
          end
        end

        S_MATCH: begin
          if (valid_q[idx] && (seq_q[idx] == ack_q)) begin
            acked_q[idx] <= 1'b1;
            cnt_q        <= '0;
            state_q      <= S_BASE;
          end else if (last_w) begin
            cnt_q   <= '0;
            state_q <= S_BASE;
          end else begin
            cnt_q <= cnt_q + CW'(1);
          end
        end

        S_BASE: begin
          if (valid_q[idx] && acked_q[idx] && (seq_q[idx] == want)) begin
            // Window base moves up; the freed slot takes the next frame.
            base_q       <= want;
            sent_q[idx]  <= 1'b0;
            acked_q[idx] <= 1'b0;
            if (has_more) begin
              seq_q[idx]   <= next_q;
              valid_q[idx] <= 1'b1;
              next_q       <= next_q + 32'd1;
            end else begin
              valid_q[idx] <= 1'b0;
            end
            retry_q <= 8'd0;
            cnt_q   <= '0;
            again_q <= 1'b0;
            ret_q   <= S_BASE;
            state_q <= S_TX;
          end else if (last_w) begin
            state_q <= S_FINAL;
          end else begin
            cnt_q <= cnt_q + CW'(1);
          end
        end

        S_TX: begin
          if (!need || (n_q >= 5'(SEND_CAP)) || out_free) begin
            if (need) begin
              sent_q[idx] <= 1'b1;
              if (n_q < 5'(SEND_CAP)) begin
                out_valid_q     <= 1'b1;
                out_q.is_send   <= 1'b1;
                out_q.is_resend <= again_q;
                out_q.slot      <= 4'(idx);
                out_q.send_seq  <= seq_q[idx];
                out_q.status    <= ST_RUNNING;
                out_q.last      <= 1'b0;
                n_q             <= n_q + 5'd1;
              end
            end
            if (last_w) begin
              cnt_q   <= '0;
              state_q <= ret_q;
            end else begin
              cnt_q <= cnt_q + CW'(1);
            end
          end
        end

        S_FINAL: begin
          if (out_free) begin
            out_valid_q     <= 1'b1;
            out_q.is_send   <= 1'b0;
            out_q.is_resend <= 1'b0;
            out_q.slot      <= 4'd0;
            out_q.send_seq  <= 32'd0;
            out_q.status    <= status_q;
            out_q.last      <= 1'b1;
            state_q         <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### hw/rtl/selective_repeat_sender_window.sv
// Sender side of a selective-repeat ARQ window. Each request (start,
// acknowledge, timeout tick, completed notice) yields zero or more send orders
// in slot order, followed by one closing result with last set that carries the
// status. A request is decoded and parked in a two-entry queue, so the input
// side keeps taking requests while the window engine works, until the queue is
// full; the engine visits one window slot per clock unless a send order waits
// for the output register. A start runs a clearing pass over all slots, then a
// send pass over the w live slots; an acknowledge runs a match search over the
// window, then, per slot the base advances over, a base search and a send
// pass, then a closing base search; a timeout below the retry limit runs a
// resend pass over the window, and a completed notice goes straight to the
// closing result, where w is the effective window size. Each send order also
// waits for the output register to be free. Configuration writes are taken in
// every cycle and must only be issued while the block is idle.
`include "assert_macros.svh"

module selective_repeat_sender_window
  import srsw_pkg::*;
#(
  parameter int unsigned WINDOW_SLOTS = DEF_WINDOW_SLOTS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  // The send pass never reports more than sixteen slots, so the usable window
  // is capped at the smaller of the slot count and sixteen.
  localparam logic [4:0] WIN_CAP = (WINDOW_SLOTS < SEND_CAP) ? 5'(WINDOW_SLOTS)
                                                            : 5'(SEND_CAP);

  logic [4:0]  window_size_q;
  logic [31:0] total_packets_q;
  logic [7:0]  max_retry_q;
  logic [4:0]  w_eff;

  logic        q_valid;
  logic        q_pop;
  cmd_t        q_cmd;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_size_q   <= RST_WINDOW_SIZE;
      total_packets_q <= RST_TOTAL_PACKETS;
      max_retry_q     <= RST_MAX_RETRY;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_WINDOW_SIZE:   window_size_q   <= cfg_data_i[4:0];
        CFG_TOTAL_PACKETS: total_packets_q <= cfg_data_i;
        CFG_MAX_RETRY:     max_retry_q     <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // A window size of zero behaves as one; anything above the cap is clipped.
  always_comb begin
    if (window_size_q == 5'd0) begin
      w_eff = 5'd1;
    end else if (window_size_q > WIN_CAP) begin
      w_eff = WIN_CAP;
    end else begin
      w_eff = window_size_q;
    end
  end

  srsw_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .q_valid_o  (q_valid),
    .q_pop_i    (q_pop),
    .q_cmd_o    (q_cmd)
  );

  srsw_back #(
    .WINDOW_SLOTS (WINDOW_SLOTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_cmd_i     (q_cmd),
    .w_eff_i     (w_eff),
    .total_i     (total_packets_q),
    .max_retry_i (max_retry_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

  // A send order is always a running, non-final result.
  `ASSERT_IMP(a_send_running, out_valid_o && out_o.is_send, (out_o.status == ST_RUNNING) && !out_o.last)
  // A retransmission is always a send order.
  `ASSERT_IMP(a_resend_is_send, out_valid_o && out_o.is_resend, out_o.is_send)
  // The closing result is last and carries no slot or sequence number.
  `ASSERT_IMP(a_final_clean, out_valid_o && !out_o.is_send, out_o.last && (out_o.slot == 4'd0) && (out_o.send_seq == 32'd0))
  // A retry limit write lands in the register on the next cycle.
  `ASSERT_NXT(a_cfg_retry, cfg_valid_i && cfg_ready_o && (cfg_index_i == CFG_MAX_RETRY), max_retry_q == $past(cfg_data_i[7:0]))

endmodule
